>>> sv/biu_pkg.sv
// ----------------------------------------------------------------------------
// biu_pkg
// shared types and constants for the bicubic upscaler
// ----------------------------------------------------------------------------
package biu_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_SCALE_DEF  = 8;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [10:0] coord_x;
        logic [10:0] coord_y;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_FRAC,
        ST_READ,
        ST_COL,
        ST_DONE
    } state_t;

endpackage

>>> sv/bicubic_image_upscaler_top.sv
// ----------------------------------------------------------------------------
// bicubic_image_upscaler_top
// catmull-rom bicubic upscaler over a single-port rgba frame store
// ----------------------------------------------------------------------------
// Loads can follow back to back. A query runs through coordinate mapping
// (ST_MAP, ST_FRAC), reading the 16 neighbors from the single-port frame
// store (one neighbor per cycle), 20 passes of the shared horner kernel
// (16 row filters, 4 column filters) and ST_DONE, which posts the result.
// No item is taken while a query runs or its result waits, and
// configuration writes are taken only while no query runs. The store is
// undefined after reset; a query must only touch loaded pixels.
module bicubic_image_upscaler_top
    import biu_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_SCALE  = MAX_SCALE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;

    logic [XW:0] width_reg;
    logic [YW:0] height_reg;
    logic [SW-1:0] scale_reg;

    state_t state_reg, state_next;
    logic [10:0] qx_reg, qy_reg;
    logic signed [12:0] bx_reg, by_reg;
    logic [15:0] tx_reg, ty_reg;
    logic [4:0] rcnt_reg;
    logic rvalid_reg;
    logic [3:0] rwhere_reg;
    logic [7:0] samp_reg [16][4];
    logic [4:0] kcnt_reg;
    logic kbusy_reg;
    logic signed [27:0] rowv_reg [4][4];
    logic [7:0] res_reg [4];
    logic out_valid_reg;

    // axis mapping by reciprocal multiplication
    logic signed [13:0] numx, numy;
    logic [4:0] den;
    logic [25:0] rcp;
    logic [37:0] qpx, qpy;
    logic signed [12:0] qx, qy;
    logic [4:0] rx, ry;
    logic [20:0] vx, vy;
    logic [46:0] fpx, fpy;
    logic [15:0] fx, fy;

    // 2^26 / (2 * s) rounded up
    function automatic logic [25:0] recip(input logic [3:0] s);
        logic [25:0] m;
        unique case (s)
            4'd1:    m = 26'((2**25 + 0) / 1);
            4'd2:    m = 26'((2**25 + 1) / 2);
            4'd3:    m = 26'((2**25 + 2) / 3);
            4'd4:    m = 26'((2**25 + 3) / 4);
            4'd5:    m = 26'((2**25 + 4) / 5);
            4'd6:    m = 26'((2**25 + 5) / 6);
            4'd7:    m = 26'((2**25 + 6) / 7);
            4'd8:    m = 26'((2**25 + 7) / 8);
            4'd9:    m = 26'((2**25 + 8) / 9);
            4'd10:   m = 26'((2**25 + 9) / 10);
            4'd11:   m = 26'((2**25 + 10) / 11);
            4'd12:   m = 26'((2**25 + 11) / 12);
            4'd13:   m = 26'((2**25 + 12) / 13);
            4'd14:   m = 26'((2**25 + 13) / 14);
            4'd15:   m = 26'((2**25 + 14) / 15);
            default: m = '0;
        endcase
        return m;
    endfunction

    assign den  = 5'({scale_reg, 1'b0});
    assign numx = $signed({2'b0, qx_reg, 1'b1}) - $signed(14'(scale_reg));
    assign numy = $signed({2'b0, qy_reg, 1'b1}) - $signed(14'(scale_reg));
    assign rcp  = recip(4'(scale_reg));

    // negative numerators are above -den, so their floor is -1
    assign qpx = {26'd0, numx[11:0]} * {12'd0, rcp};
    assign qpy = {26'd0, numy[11:0]} * {12'd0, rcp};
    assign qx  = numx[13] ? -13'sd1 : $signed({1'b0, qpx[37:26]});
    assign qy  = numy[13] ? -13'sd1 : $signed({1'b0, qpy[37:26]});

    // fraction rounded half up to 16 bits
    assign rx  = 5'(numx - 14'(bx_reg * $signed({1'b0, den})));
    assign ry  = 5'(numy - 14'(by_reg * $signed({1'b0, den})));
    assign vx  = {rx, 16'd0} + 21'(scale_reg);
    assign vy  = {ry, 16'd0} + 21'(scale_reg);
    assign fpx = {26'd0, vx} * {21'd0, rcp};
    assign fpy = {26'd0, vy} * {21'd0, rcp};
    assign fx  = (fpx[46:42] != 5'd0) ? 16'hFFFF : fpx[41:26];
    assign fy  = (fpy[46:42] != 5'd0) ? 16'hFFFF : fpy[41:26];

    // neighbor address
    logic signed [13:0] sxr, syr;
    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    always_comb
    begin
        sxr = 14'(bx_reg) + 14'(rcnt_reg[1:0]) - 14'sd1;
        syr = 14'(by_reg) + 14'(rcnt_reg[3:2]) - 14'sd1;
        if (sxr < 0) sx = '0;
        else if (sxr > $signed(14'(width_reg) - 14'sd1)) sx = XW'(width_reg - 1'b1);
        else sx = XW'(sxr);
        if (syr < 0) sy = '0;
        else if (syr > $signed(14'(height_reg) - 14'sd1)) sy = YW'(height_reg - 1'b1);
        else sy = YW'(syr);
    end

    logic load_go, query_go;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign load_go   = in_valid && in_ready && (in_data.req_type == REQ_LOAD);
    assign query_go  = in_valid && in_ready && (in_data.req_type == REQ_QUERY);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (load_go && (32'(in_data.coord_x) < MAX_WIDTH)
            && (32'(in_data.coord_y) < MAX_HEIGHT))
            mem[{YW'(in_data.coord_y), XW'(in_data.coord_x)}] <=
                {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
        if (state_reg == ST_READ) rd_reg <= mem[{sy, sx}];
    end

    // kernel
    logic kstart, kdone;
    logic signed [27:0] kp [4];
    logic [15:0] kt;
    logic signed [27:0] kres;
    logic [1:0] kch, kj;
    assign kch = kcnt_reg[4:3] ;
    always_comb
    begin
        kj = kcnt_reg[1:0];
        kt = tx_reg;
        for (int i = 0; i < 4; i++)
            kp[i] = 28'($signed({1'b0, samp_reg[{kj, 2'(i)}][kch], 16'd0}));
        if (kcnt_reg[2])
        begin
            kt = ty_reg;
            for (int i = 0; i < 4; i++) kp[i] = rowv_reg[kch][i];
        end
    end

    biu_cr u_cr (
        .clk  (clk),
        .rst_n(rst_n),
        .start(kstart),
        .p0   (kp[0]),
        .p1   (kp[1]),
        .p2   (kp[2]),
        .p3   (kp[3]),
        .t    (kt),
        .done (kdone),
        .res  (kres)
    );

    assign kstart = (state_reg == ST_COL) && !kbusy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (query_go) state_next = ST_MAP;
            ST_MAP:  state_next = ST_FRAC;
            ST_FRAC: state_next = ST_READ;
            ST_READ: if (rvalid_reg && rwhere_reg == 4'd15) state_next = ST_COL;
            ST_COL:  if (kdone && kcnt_reg == 5'd28) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= (XW+1)'(1);
            height_reg    <= (YW+1)'(1);
            scale_reg     <= SW'(1);
            out_valid_reg <= 1'b0;
            rcnt_reg      <= '0;
            rvalid_reg    <= 1'b0;
            kcnt_reg      <= '0;
            kbusy_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WIDTH:
                        width_reg <= (cfg_data == 0) ? (XW+1)'(1) :
                            (32'(cfg_data) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) :
                            (XW+1)'(cfg_data);
                    REG_HEIGHT:
                        height_reg <= (cfg_data == 0) ? (YW+1)'(1) :
                            (32'(cfg_data) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) :
                            (YW+1)'(cfg_data);
                    REG_SCALE:
                        scale_reg <= (cfg_data[3:0] == 0) ? SW'(1) :
                            (32'(cfg_data[3:0]) > MAX_SCALE) ? SW'(MAX_SCALE) :
                            SW'(cfg_data[3:0]);
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE) out_valid_reg <= 1'b1;
            rvalid_reg <= (state_reg == ST_READ) && !rcnt_reg[4];
            if (state_reg == ST_MAP) rcnt_reg <= '0;
            else if (state_reg == ST_READ && !rcnt_reg[4]) rcnt_reg <= rcnt_reg + 5'd1;
            if (state_reg == ST_READ) kcnt_reg <= '0;
            if (kstart) kbusy_reg <= 1'b1;
            if (kdone)
            begin
                kbusy_reg <= 1'b0;
                kcnt_reg  <= kcnt_reg + (kcnt_reg[2] ? 5'd4 : 5'd1);
            end
        end
    end

    // sequence per channel: 4 row passes (kcnt[2]=0), then 1 column pass
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            qx_reg <= in_data.coord_x;
            qy_reg <= in_data.coord_y;
        end
        if (state_reg == ST_MAP)
        begin
            bx_reg <= qx;
            by_reg <= qy;
        end
        if (state_reg == ST_FRAC)
        begin
            tx_reg <= fx;
            ty_reg <= fy;
        end
        if (state_reg == ST_READ) rwhere_reg <= rcnt_reg[3:0];
        if (rvalid_reg)
            for (int c = 0; c < 4; c++) samp_reg[rwhere_reg][c] <= rd_reg[8*c +: 8];
        if (kdone)
        begin
            if (!kcnt_reg[2]) rowv_reg[kch][kj] <= kres;
            else res_reg[kch] <= (kres < 0) ? 8'd0 :
                (kres[27:24] != 4'd0) ? 8'd255 : kres[23:16];
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.red_out   = res_reg[0];
    assign out_data.green_out = res_reg[1];
    assign out_data.blue_out  = res_reg[2];
    assign out_data.alpha_out = res_reg[3];

endmodule

>>> sv/biu_cr.sv
// ----------------------------------------------------------------------------
// biu_cr
// multi-cycle catmull-rom kernel, one horner multiply per cycle
// ----------------------------------------------------------------------------
module biu_cr
    import biu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [27:0] p0,
    input  logic signed [27:0] p1,
    input  logic signed [27:0] p2,
    input  logic signed [27:0] p3,
    input  logic        [15:0] t,
    output logic               done,
    output logic signed [27:0] res
);

    logic signed [31:0] b2_reg, c2_reg, h_reg, p1_reg;
    logic        [15:0] t_reg;
    logic        [1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] a2, b2, c2;
    logic signed [48:0] prod;
    logic signed [32:0] hs;

    assign a2 = -32'(p0) + 32'(3 * p1) - 32'(3 * p2) + 32'(p3);
    assign b2 = 32'(2 * p0) - 32'(5 * p1) + 32'(4 * p2) - 32'(p3);
    assign c2 = 32'(p2) - 32'(p0);
    assign prod = 49'(h_reg) * $signed({1'b0, t_reg});
    assign hs = 33'(prod >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg  <= a2;
            b2_reg <= b2;
            c2_reg <= c2;
            p1_reg <= 32'(p1);
            t_reg  <= t;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                2'd0:    h_reg <= 32'(hs) + b2_reg;
                2'd1:    h_reg <= 32'(hs) + c2_reg;
                default: h_reg <= 32'(p1_reg + 32'(hs >>> 1));
            endcase
        end
    end

    assign done = done_reg;
    assign res  = 28'(h_reg);

endmodule
